// ----- rtl/smsc_pkg.sv -----
package smsc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // field and register widths
    localparam int SIGMA_W    = 32;
    localparam int MODE_W     = 2;
    localparam int MS_W       = 31;
    localparam int MASS_W     = 31;
    localparam int TS_W       = 17;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MASS      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TS        = 2'd3;

    localparam logic [MODE_W-1:0] MODE_OFF   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FOSMC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_ST    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_STLIN = 2'd3;

    localparam logic [MS_W-1:0]   MS_RST   = 31'd65536;
    localparam logic [MASS_W-1:0] MASS_RST = 31'd65536;
    localparam logic [TS_W-1:0]   TS_RST   = 17'd655;

    // shift-add multiplier: multiplier operand width and step counter width
    localparam int MUL_BW = 31;
    localparam int MUL_LW = $clog2(MUL_BW + 1);

    // linear gain of the integrator rate, doubled: 2 * 118.5
    localparam int             K237_W = 8;
    localparam logic [K237_W-1:0] K237 = 8'd237;
    localparam int             DM_W   = 40;

    // dividend of the rounded 0.4 * Ts step: 4 * Ts + 5
    localparam int DIV_W = TS_W + 3;

    typedef struct packed {
        logic              start;
        logic [MUL_LW-1:0] len;
    } mul_cmd_t;

endpackage

// ----- rtl/smsc_isqrt.sv -----
module smsc_isqrt #(
    parameter int FRAC_BITS = smsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       start,
    input  logic [smsc_pkg::SIGMA_W-1:0]               mag,
    output logic                                       busy,
    output logic [(smsc_pkg::SIGMA_W+FRAC_BITS+1)/2-1:0] root
);

    localparam int VW  = smsc_pkg::SIGMA_W + FRAC_BITS;
    localparam int SQW = (VW + 1) / 2;
    localparam int CW  = $clog2(SQW);

    logic [2*SQW-1:0] v_reg, v_next;
    logic [SQW+1:0]   rem_reg, rem_next;
    logic [SQW-1:0]   root_reg, root_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;

    logic [SQW+1:0] r;
    logic [SQW+1:0] trial;
    logic           ge;

    // one result bit per cycle, two radicand bits enter per cycle
    assign r     = {rem_reg[SQW-1:0], v_reg[2*SQW-1 -: 2]};
    assign trial = {root_reg, 2'b01};
    assign ge    = (r >= trial);

    always_comb
    begin
        v_next    = v_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            v_next    = (2*SQW)'({mag, {FRAC_BITS{1'b0}}});
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(SQW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? (r - trial) : r;
            root_next = {root_reg[SQW-2:0], ge};
            v_next    = {v_reg[2*SQW-3:0], 2'b00};
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

// ----- rtl/smsc_div10.sv -----
module smsc_div10 (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [smsc_pkg::DIV_W-1:0]   dividend,
    output logic                         busy,
    output logic [smsc_pkg::DIV_W-1:0]   quotient
);

    localparam int          DW      = smsc_pkg::DIV_W;
    localparam int          CW      = $clog2(DW);
    localparam logic [4:0]  DIVISOR = 5'd10;

    // dividend bits leave at the top while quotient bits enter at the bottom
    logic [DW-1:0] dq_reg, dq_next;
    logic [3:0]    rem_reg, rem_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;

    logic [4:0] r;
    logic [4:0] r_sub;
    logic       ge;

    assign r     = {rem_reg, dq_reg[DW-1]};
    assign ge    = (r >= DIVISOR);
    assign r_sub = r - DIVISOR;

    always_comb
    begin
        dq_next   = dq_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            dq_next   = dividend;
            rem_next  = '0;
            cnt_next  = CW'(DW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? r_sub[3:0] : r[3:0];
            dq_next  = {dq_reg[DW-2:0], ge};
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = dq_reg;

endmodule

// ----- rtl/smsc_mul.sv -----
module smsc_mul #(
    parameter int AW = 46
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  smsc_pkg::mul_cmd_t                 cmd,
    input  logic [AW-1:0]                      a,
    input  logic [smsc_pkg::MUL_BW-1:0]        b,
    output logic                               busy,
    output logic [AW+smsc_pkg::MUL_BW-1:0]     prod
);

    localparam int BW = smsc_pkg::MUL_BW;
    localparam int LW = smsc_pkg::MUL_LW;

    // after len steps with b below 2^len, {hi, lo} holds a*b << (BW - len)
    logic [AW-1:0] a_reg, a_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [BW-1:0] lo_reg, lo_next;
    logic [LW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;

    logic [AW:0] sum;

    assign sum = {1'b0, hi_reg} + (lo_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});

    always_comb
    begin
        a_next    = a_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (cmd.start)
        begin
            a_next    = a;
            hi_next   = '0;
            lo_next   = b;
            cnt_next  = cmd.len - 1'b1;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            hi_next = sum[AW:1];
            lo_next = {sum[0], lo_reg[BW-1:1]};
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
                cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg  <= a_next;
        hi_reg <= hi_next;
        lo_reg <= lo_next;
    end

    assign busy = busy_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

// ----- rtl/sliding_mode_speed_controller_top.sv -----
// Sliding-mode speed controller.
// Input channel in_valid/in_ready carries one sliding-surface sample, sigma,
// signed fixed point with FRAC_BITS fraction bits. Output channel
// out_valid/out_ready returns one saturated drive value per sample.
// Configuration channel cfg_valid/cfg_ready with cfg_index/cfg_data writes
// mode, max_speed, mass, sample_period; cfg_ready is always high and
// writes belong to idle periods.
// Items are handled one at a time. Off, first-order and deadband samples go
// straight to the result register. Super-twisting samples (mode 2, or mode 3
// outside the deadband) first run the bit-serial square root, its SQW steps
// set by SQW = (33 + FRAC_BITS)/2. They then use the shift-add multiplier,
// one multiplier bit per cycle: 31 steps for max_speed, 8 for the linear gain,
// 17 for Ts, 31 for the mass. The next sample can be taken in the cycle after
// a result enters the output register.
// A result waits in the output register while out_ready is low; the next sample
// is then accepted and computed, and holds until the output register frees.
// Reset clears the integrator and loads the register defaults: mode off,
// max_speed and mass 1.0 at Q16.16, sample_period 655 raw.
module sliding_mode_speed_controller_top #(
    parameter int FRAC_BITS = smsc_pkg::FRAC_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [smsc_pkg::SIGMA_W-1:0]   sigma,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [smsc_pkg::SIGMA_W-1:0]   drive,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [smsc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [smsc_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int SW   = smsc_pkg::SIGMA_W;
    localparam int VW   = SW + FRAC_BITS;
    localparam int SQW  = (VW + 1) / 2;
    localparam int T3W  = SQW + 2;
    localparam int BW   = smsc_pkg::MUL_BW;
    localparam int PW   = T3W + BW - (FRAC_BITS + 1);
    localparam int UW   = (PW > 33) ? PW : 33;
    localparam int SUMW = UW + 2;
    localparam int DMW  = smsc_pkg::DM_W;
    localparam int IMW  = DMW + smsc_pkg::TS_W - (FRAC_BITS + 1);
    localparam int DW   = (IMW > smsc_pkg::TS_W) ? IMW : smsc_pkg::TS_W;
    localparam int ACCW = ((DW > SW) ? DW : SW) + 2;
    localparam int AW   = (DMW > UW + 1) ? DMW : UW + 1;
    localparam int PRW  = AW + BW;
    localparam int QW   = PRW - FRAC_BITS;

    localparam logic [SW-1:0]  BAND   = SW'(((64'd1 << FRAC_BITS) + 64'd100) / 64'd200);
    localparam logic [DMW-1:0] DM_OFS = DMW'(64'd75 << (FRAC_BITS - 2));
    localparam longint LIM3_L = ((64'sd200 << FRAC_BITS) > 64'sd2147483647) ?
                                64'sd2147483647 : (64'sd200 << FRAC_BITS);
    localparam logic signed [ACCW-1:0] LIM2  = ACCW'(64'sd1 << FRAC_BITS);
    localparam logic signed [ACCW-1:0] NLIM2 = -LIM2;
    localparam logic signed [ACCW-1:0] LIM3  = ACCW'(LIM3_L);
    localparam logic signed [ACCW-1:0] NLIM3 = -LIM3;
    localparam logic [QW-1:0] Q_NEG_MAX = QW'(64'h8000_0000);
    localparam logic [QW-1:0] Q_POS_MAX = QW'(64'h7FFF_FFFF);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ROOT = 4'd1;
    localparam logic [3:0] S_M1GO = 4'd2;
    localparam logic [3:0] S_M1W  = 4'd3;
    localparam logic [3:0] S_LIN  = 4'd4;
    localparam logic [3:0] S_M2GO = 4'd5;
    localparam logic [3:0] S_M2W  = 4'd6;
    localparam logic [3:0] S_INT  = 4'd7;
    localparam logic [3:0] S_SUM  = 4'd8;
    localparam logic [3:0] S_M3GO = 4'd9;
    localparam logic [3:0] S_M3W  = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;
    localparam logic [3:0] S_DONE = 4'd12;

    // configuration
    logic [smsc_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [smsc_pkg::MS_W-1:0]   ms_reg, ms_next;
    logic [smsc_pkg::MASS_W-1:0] mass_reg, mass_next;
    logic [smsc_pkg::TS_W-1:0]   ts_reg, ts_next;

    // control
    logic [3:0]              state_reg, state_next;
    logic                    out_valid_reg, out_valid_next;
    logic signed [SW-1:0]    integ_reg, integ_next;

    // datapath
    logic [SW-1:0]           mag_reg, mag_next;
    logic                    neg_reg, neg_next;
    logic                    zero_reg, zero_next;
    logic [T3W-1:0]          t3_reg, t3_next;
    logic [UW-1:0]           u1m_reg, u1m_next;
    logic [DMW-1:0]          dm_reg, dm_next;
    logic [DW-1:0]           delta_reg, delta_next;
    logic signed [SUMW-1:0]  sum_reg, sum_next;
    logic signed [SW-1:0]    res_reg, res_next;
    logic signed [SW-1:0]    drive_reg, drive_next;

    // units
    logic                        root_start;
    logic                        root_busy;
    logic [SQW-1:0]              root;
    logic                        div_busy;
    logic [smsc_pkg::DIV_W-1:0]  div_q;
    logic [smsc_pkg::DIV_W-1:0]  div_dividend;
    smsc_pkg::mul_cmd_t          mul_cmd;
    logic [AW-1:0]               mul_a;
    logic [BW-1:0]               mul_b;
    logic                        mul_busy;
    logic [PRW-1:0]              mul_prod;

    // combinational helpers
    logic                        accept;
    logic                        load;
    logic [SW-1:0]               mag_in;
    logic signed [ACCW-1:0]      delta_ext;
    logic signed [ACCW-1:0]      acc;
    logic signed [ACCW-1:0]      lim;
    logic signed [ACCW-1:0]      nlim;
    logic signed [ACCW-1:0]      acc_clamped;
    logic signed [SUMW-1:0]      u1_ext;
    logic signed [SUMW-1:0]      sum_calc;
    logic [SUMW-1:0]             sum_abs;
    logic [QW-1:0]               q;
    logic [SW-1:0]               q_sat;
    logic signed [SW-1:0]        res_sat;

    assign in_ready  = (state_reg == S_IDLE);
    assign accept    = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    assign mag_in = sigma[SW-1] ? SW'(-sigma) : SW'(sigma);

    assign div_dividend = smsc_pkg::DIV_W'({ts_reg, 2'b00}) + smsc_pkg::DIV_W'(5);

    // integrator update, step sign follows sigma
    assign delta_ext   = {{(ACCW-DW){1'b0}}, delta_reg};
    assign acc         = ACCW'(integ_reg) + (neg_reg ? -delta_ext : delta_ext);
    assign lim         = (mode_reg == smsc_pkg::MODE_ST) ? LIM2 : LIM3;
    assign nlim        = (mode_reg == smsc_pkg::MODE_ST) ? NLIM2 : NLIM3;
    assign acc_clamped = (acc > lim) ? lim : ((acc < nlim) ? nlim : acc);

    assign u1_ext   = {{(SUMW-UW){1'b0}}, u1m_reg};
    assign sum_calc = (neg_reg ? -u1_ext : u1_ext) + SUMW'(integ_reg);
    assign sum_abs  = sum_reg[SUMW-1] ? SUMW'(-sum_reg) : SUMW'(sum_reg);

    // output scaling: truncated magnitude, then saturate to 32 bits
    assign q = mul_prod[PRW-1:FRAC_BITS];
    always_comb
    begin
        if (sum_reg[SUMW-1])
        begin
            q_sat   = (q > Q_NEG_MAX) ? SW'(Q_NEG_MAX) : q[SW-1:0];
            res_sat = SW'(32'd0 - q_sat);
        end
        else
        begin
            q_sat   = (q > Q_POS_MAX) ? SW'(Q_POS_MAX) : q[SW-1:0];
            res_sat = q_sat;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        ms_next    = ms_reg;
        mass_next  = mass_reg;
        ts_next    = ts_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                smsc_pkg::REG_MODE:      mode_next = cfg_data[smsc_pkg::MODE_W-1:0];
                smsc_pkg::REG_MAX_SPEED: ms_next   = cfg_data[smsc_pkg::MS_W-1:0];
                smsc_pkg::REG_MASS:      mass_next = cfg_data[smsc_pkg::MASS_W-1:0];
                smsc_pkg::REG_TS:        ts_next   = cfg_data[smsc_pkg::TS_W-1:0];
                default:                 mode_next = mode_reg;
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        integ_next = integ_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        t3_next    = t3_reg;
        u1m_next   = u1m_reg;
        dm_next    = dm_reg;
        delta_next = delta_reg;
        sum_next   = sum_reg;
        res_next   = res_reg;
        drive_next = drive_reg;
        load       = 1'b0;
        root_start = 1'b0;
        mul_cmd    = '0;
        mul_a      = '0;
        mul_b      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    mag_next  = mag_in;
                    neg_next  = sigma[SW-1];
                    zero_next = (sigma == '0);
                    case (mode_reg)
                        smsc_pkg::MODE_OFF:
                        begin
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                        smsc_pkg::MODE_FOSMC:
                        begin
                            res_next   = sigma[SW-1] ? '0 : sigma;
                            state_next = S_DONE;
                        end
                        smsc_pkg::MODE_ST:
                        begin
                            root_start = 1'b1;
                            state_next = S_ROOT;
                        end
                        smsc_pkg::MODE_STLIN:
                        begin
                            // a sample on the deadband bound is inside it
                            if (mag_in > BAND)
                            begin
                                root_start = 1'b1;
                                state_next = S_ROOT;
                            end
                            else
                            begin
                                res_next   = '0;
                                state_next = S_DONE;
                            end
                        end
                        default:
                        begin
                            res_next   = '0;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_ROOT:
            begin
                if (!root_busy && !div_busy)
                begin
                    t3_next    = T3W'({root, 1'b0}) + T3W'(root);
                    delta_next = zero_reg ? '0 : DW'(div_q);
                    state_next = S_M1GO;
                end
            end
            S_M1GO:
            begin
                mul_cmd.start = 1'b1;
                if (mode_reg == smsc_pkg::MODE_ST)
                begin
                    mul_a       = AW'(t3_reg);
                    mul_b       = BW'(ms_reg);
                    mul_cmd.len = smsc_pkg::MUL_LW'(smsc_pkg::MS_W);
                end
                else
                begin
                    mul_a       = AW'(mag_reg);
                    mul_b       = BW'(smsc_pkg::K237);
                    mul_cmd.len = smsc_pkg::MUL_LW'(smsc_pkg::K237_W);
                end
                state_next = S_M1W;
            end
            S_M1W:
            begin
                if (!mul_busy)
                begin
                    if (mode_reg == smsc_pkg::MODE_ST)
                    begin
                        u1m_next   = UW'(mul_prod[FRAC_BITS+1 +: PW]);
                        state_next = S_INT;
                    end
                    else
                    begin
                        state_next = S_LIN;
                    end
                end
            end
            S_LIN:
            begin
                dm_next    = mul_prod[BW-smsc_pkg::K237_W +: DMW] + DM_OFS;
                u1m_next   = UW'(t3_reg) + UW'(mag_reg);
                state_next = S_M2GO;
            end
            S_M2GO:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.len   = smsc_pkg::MUL_LW'(smsc_pkg::TS_W);
                mul_a         = AW'(dm_reg);
                mul_b         = BW'(ts_reg);
                state_next    = S_M2W;
            end
            S_M2W:
            begin
                if (!mul_busy)
                begin
                    delta_next = DW'(mul_prod[BW-smsc_pkg::TS_W+FRAC_BITS+1 +: IMW]);
                    state_next = S_INT;
                end
            end
            S_INT:
            begin
                integ_next = SW'(acc_clamped);
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next   = sum_calc;
                state_next = S_M3GO;
            end
            S_M3GO:
            begin
                mul_cmd.start = 1'b1;
                mul_cmd.len   = smsc_pkg::MUL_LW'(smsc_pkg::MASS_W);
                mul_a         = AW'(sum_abs);
                mul_b         = BW'(mass_reg);
                state_next    = S_M3W;
            end
            S_M3W:
            begin
                if (!mul_busy)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                res_next   = res_sat;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    drive_next = res_reg;
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = load || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            integ_reg     <= '0;
            mode_reg      <= smsc_pkg::MODE_OFF;
            ms_reg        <= smsc_pkg::MS_RST;
            mass_reg      <= smsc_pkg::MASS_RST;
            ts_reg        <= smsc_pkg::TS_RST;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            integ_reg     <= integ_next;
            mode_reg      <= mode_next;
            ms_reg        <= ms_next;
            mass_reg      <= mass_next;
            ts_reg        <= ts_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        t3_reg    <= t3_next;
        u1m_reg   <= u1m_next;
        dm_reg    <= dm_next;
        delta_reg <= delta_next;
        sum_reg   <= sum_next;
        res_reg   <= res_next;
        drive_reg <= drive_next;
    end

    smsc_isqrt #(
        .FRAC_BITS (FRAC_BITS)
    ) u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (root_start),
        .mag   (mag_in),
        .busy  (root_busy),
        .root  (root)
    );

    smsc_div10 u_div10 (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .dividend (div_dividend),
        .busy     (div_busy),
        .quotient (div_q)
    );

    smsc_mul #(
        .AW (AW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (mul_cmd),
        .a     (mul_a),
        .b     (mul_b),
        .busy  (mul_busy),
        .prod  (mul_prod)
    );

endmodule
